[hw/rtl/dwa_pkg.sv]
// Shared types, constants and codes of the downsample window aggregator.
`default_nettype none

package dwa_pkg;

  localparam int DWA_MAX_WINDOW  = 256;
  localparam int DWA_SAMPLE_BITS = 32;
  localparam int DWA_FRAC_BITS   = 16;

  localparam int VALUE_W    = 32;
  localparam int RESULT_W   = 64;
  localparam int MODE_W     = 4;
  localparam int SPO_W      = 9;
  localparam int LEAD_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE = 2'd0,
    CFG_SPO  = 2'd1,
    CFG_LEAD = 2'd2
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_AVG    = 4'd0,
    MODE_COUNT  = 4'd1,
    MODE_DIFF   = 4'd2,
    MODE_FIRST  = 4'd3,
    MODE_LAST   = 4'd4,
    MODE_MAX    = 4'd5,
    MODE_MEDIAN = 4'd6,
    MODE_MIN    = 4'd7,
    MODE_MUL    = 4'd8,
    MODE_RANGE  = 4'd9,
    MODE_STDDEV = 4'd10,
    MODE_SUM    = 4'd11
  } mode_e;

  typedef enum logic {
    MUL_PROD = 1'b0,
    MUL_SQ   = 1'b1
  } mul_sel_e;

  typedef enum logic [1:0] {
    DIV_MEAN = 2'd0,
    DIV_AVG  = 2'd1,
    DIV_STD  = 2'd2
  } div_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_UPD,
    ST_MULP,
    ST_DIVM,
    ST_MULS_GO,
    ST_MULS,
    ST_INS_GO,
    ST_INS_CMP,
    ST_INS_FIN,
    ST_STEP,
    ST_CLOSE,
    ST_DIVA,
    ST_DIVS,
    ST_SQRT,
    ST_MED_HI,
    ST_MED_LO,
    ST_MED_B,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic     in_ready;
    logic     init;
    logic     acc;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic     prod_load;
    logic     div_start;
    div_sel_e div_sel;
    logic     mean_load;
    logic     sq_load;
    logic     ins_go;
    logic     ins_cmp;
    logic     ins_put0;
    logic     step;
    logic     close_prep;
    logic     calc_div;
    logic     sqrt_start;
    logic     calc_sqrt;
    logic     med_hi;
    logic     med_lo;
    logic     med_b;
    logic     emit;
  } dwa_cmd_t;

  typedef struct packed {
    logic              in_valid;
    logic              present;
    logic              pc_zero;
    logic [MODE_W-1:0] mode;
    logic              close;
    logic              ins_gt;
    logic              ins_j_zero;
    logic              mul_done;
    logic              div_done;
    logic              sqrt_done;
    logic              out_free;
  } dwa_status_t;

endpackage

`default_nettype wire

[hw/rtl/dwa_in_if.sv]
// Input sample channel of the downsample window aggregator.
`default_nettype none

interface dwa_in_if;
  import dwa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] sample_value;
  logic                      sample_present;
  logic                      last_sample;

  modport source (output valid, output sample_value, output sample_present,
                  output last_sample, input ready);
  modport sink (input valid, input sample_value, input sample_present,
                input last_sample, output ready);
endinterface

`default_nettype wire

[hw/rtl/dwa_out_if.sv]
// Result channel of the downsample window aggregator.
`default_nettype none

interface dwa_out_if;
  import dwa_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] result_value;
  logic                       result_present;
  logic                       result_saturated;

  modport source (output valid, output result_value, output result_present,
                  output result_saturated, input ready);
  modport sink (input valid, input result_value, input result_present,
                input result_saturated, output ready);
endinterface

`default_nettype wire

[hw/rtl/dwa_ram.sv]
// Generic one-write, one-read RAM with registered read data.
`default_nettype none

module dwa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hw/rtl/dwa_mul.sv]
// Sequential saturating fixed-point multiplier built on one 32x32 multiplier.
`default_nettype none

module dwa_mul import dwa_pkg::*; #(
  parameter int FRAC_BITS = DWA_FRAC_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] a_i,
  input  wire logic signed [63:0] b_i,
  output logic                    done_o,
  output logic signed [63:0]      res_o,
  output logic                    clip_o
);

  logic [63:0]  ua_q, ub_q;
  logic         neg_q;
  logic [63:0]  p_q;
  logic [127:0] acc_q;
  logic [2:0]   cnt_q;
  logic         busy_q, done_q;
  logic [31:0]  pa, pb;
  logic [2:0]   prev;
  logic [127:0] p_sh;
  logic [127:0] sh;
  logic [63:0]  limit;

  // Partial products a0*b0, a0*b1, a1*b0, a1*b1 in cnt order.
  always_comb begin
    pa = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
    pb = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
    prev = cnt_q - 3'd1;
    case (prev)
      3'd0:    p_sh = {64'd0, p_q};
      3'd1:    p_sh = {32'd0, p_q, 32'd0};
      3'd2:    p_sh = {32'd0, p_q, 32'd0};
      default: p_sh = {p_q, 64'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 3'd4);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= a_i[63] ? (64'd0 - a_i) : a_i;
      ub_q  <= b_i[63] ? (64'd0 - b_i) : b_i;
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q <= 3'd3) begin
        p_q <= pa * pb;
      end
      if (cnt_q != 3'd0) begin
        acc_q <= acc_q + p_sh;
      end
    end
  end

  always_comb begin
    sh     = acc_q >> FRAC_BITS;
    limit  = neg_q ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    clip_o = (sh[127:64] != 64'd0) || (sh[63:0] > limit);
    if (clip_o) begin
      res_o = neg_q ? 64'sh8000_0000_0000_0000 : 64'sh7fff_ffff_ffff_ffff;
    end else begin
      res_o = neg_q ? (64'd0 - sh[63:0]) : sh[63:0];
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

[hw/rtl/dwa_div.sv]
// Unsigned 64-bit by window-count divider, eight quotient bits per cycle.
`default_nettype none

module dwa_div #(
  parameter int DW = 9
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [63:0]   dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               done_o,
  output logic [63:0]        quot_o
);

  localparam int BITS_PER_CYC = 8;
  localparam int CYCLES       = 64 / BITS_PER_CYC;
  localparam int CW           = $clog2(CYCLES);

  logic [63:0]   dd_q, dd_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   t;

  // The remainder stays below the divisor, so each step is a narrow subtract.
  always_comb begin
    dd_d  = dd_q;
    rem_d = rem_q;
    t     = '0;
    for (int k = 0; k < BITS_PER_CYC; k++) begin
      t = {rem_d, dd_d[63]};
      if (t >= {1'b0, dvs_q}) begin
        rem_d = DW'(t - {1'b0, dvs_q});
        dd_d  = {dd_d[62:0], 1'b1};
      end else begin
        rem_d = t[DW-1:0];
        dd_d  = {dd_d[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(CYCLES - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(CYCLES - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dd_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dd_q  <= dd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dd_q;

endmodule

`default_nettype wire

[hw/rtl/dwa_sqrt.sv]
// Bit-serial integer square root of a value scaled up by the fraction bits.
`default_nettype none

module dwa_sqrt import dwa_pkg::*; #(
  parameter int FRAC_BITS = DWA_FRAC_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] q_i,
  output logic             done_o,
  output logic [63:0]      root_o
);

  logic [127:0] rad_q;
  logic [65:0]  rem_q, rem_n;
  logic [63:0]  root_q;
  logic [5:0]   cnt_q;
  logic         busy_q, done_q;
  logic [65:0]  trial;

  always_comb begin
    rem_n = {rem_q[63:0], rad_q[127:126]};
    trial = {root_q, 2'b01};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd63);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= {64'd0, q_i} << FRAC_BITS;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[125:0], 2'b00};
      if (rem_n >= trial) begin
        rem_q  <= rem_n - trial;
        root_q <= {root_q[62:0], 1'b1};
      end else begin
        rem_q  <= rem_n;
        root_q <= {root_q[62:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

[hw/rtl/dwa_ctrl.sv]
// Sequencing state machine of the downsample window aggregator.
`default_nettype none

module dwa_ctrl import dwa_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dwa_status_t status_i,
  output dwa_cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (status_i.in_valid) state_d = ST_UPD;
      end
      ST_UPD: begin
        if (!status_i.present)     state_d = ST_STEP;
        else if (status_i.pc_zero) state_d = ST_INS_GO;
        else                       state_d = ST_MULP;
      end
      ST_MULP: begin
        if (status_i.mul_done) state_d = ST_DIVM;
      end
      ST_DIVM: begin
        if (status_i.div_done) state_d = ST_MULS_GO;
      end
      ST_MULS_GO: state_d = ST_MULS;
      ST_MULS: begin
        if (status_i.mul_done) state_d = ST_INS_GO;
      end
      ST_INS_GO: begin
        state_d = status_i.pc_zero ? ST_STEP : ST_INS_CMP;
      end
      ST_INS_CMP: begin
        if (!status_i.ins_gt)        state_d = ST_STEP;
        else if (status_i.ins_j_zero) state_d = ST_INS_FIN;
      end
      ST_INS_FIN: state_d = ST_STEP;
      ST_STEP: begin
        state_d = status_i.close ? ST_CLOSE : ST_IDLE;
      end
      ST_CLOSE: begin
        state_d = ST_EMIT;
        if (!status_i.pc_zero) begin
          if (status_i.mode == MODE_AVG)         state_d = ST_DIVA;
          else if (status_i.mode == MODE_STDDEV) state_d = ST_DIVS;
          else if (status_i.mode == MODE_MEDIAN) state_d = ST_MED_HI;
        end
      end
      ST_DIVA: begin
        if (status_i.div_done) state_d = ST_EMIT;
      end
      ST_DIVS: begin
        if (status_i.div_done) state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (status_i.sqrt_done) state_d = ST_EMIT;
      end
      ST_MED_HI: state_d = ST_MED_LO;
      ST_MED_LO: state_d = ST_MED_B;
      ST_MED_B:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: cmd_o.in_ready = 1'b1;
      ST_UPD: begin
        if (status_i.present) begin
          if (status_i.pc_zero) begin
            cmd_o.init = 1'b1;
          end else begin
            cmd_o.acc       = 1'b1;
            cmd_o.mul_start = 1'b1;
            cmd_o.mul_sel   = MUL_PROD;
          end
        end
      end
      ST_MULP: begin
        if (status_i.mul_done) begin
          cmd_o.prod_load = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_MEAN;
        end
      end
      ST_DIVM: cmd_o.mean_load = status_i.div_done;
      ST_MULS_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MUL_SQ;
      end
      ST_MULS: cmd_o.sq_load = status_i.mul_done;
      ST_INS_GO: begin
        if (status_i.pc_zero) cmd_o.ins_put0 = 1'b1;
        else                  cmd_o.ins_go   = 1'b1;
      end
      ST_INS_CMP: cmd_o.ins_cmp  = 1'b1;
      ST_INS_FIN: cmd_o.ins_put0 = 1'b1;
      ST_STEP:    cmd_o.step     = 1'b1;
      ST_CLOSE: begin
        cmd_o.close_prep = 1'b1;
        if (!status_i.pc_zero) begin
          if (status_i.mode == MODE_AVG) begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = DIV_AVG;
          end else if (status_i.mode == MODE_STDDEV) begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = DIV_STD;
          end
        end
      end
      ST_DIVA:   cmd_o.calc_div   = status_i.div_done;
      ST_DIVS:   cmd_o.sqrt_start = status_i.div_done;
      ST_SQRT:   cmd_o.calc_sqrt  = status_i.sqrt_done;
      ST_MED_HI: cmd_o.med_hi     = 1'b1;
      ST_MED_LO: cmd_o.med_lo     = 1'b1;
      ST_MED_B:  cmd_o.med_b      = 1'b1;
      ST_EMIT:   cmd_o.emit       = status_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/dwa_dp.sv]
// Datapath: configuration, window accumulators, sorted store and result register.
`default_nettype none

module dwa_dp import dwa_pkg::*; #(
  parameter int MAX_WINDOW  = DWA_MAX_WINDOW,
  parameter int SAMPLE_BITS = DWA_SAMPLE_BITS,
  parameter int FRAC_BITS   = DWA_FRAC_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  dwa_in_if.sink                     in_i,
  dwa_out_if.source                  out_o,
  input  wire dwa_cmd_t              cmd_i,
  output dwa_status_t                status_o
);

  localparam int SB    = SAMPLE_BITS;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int TW    = (CNT_W > SPO_W) ? CNT_W : SPO_W;

  localparam logic signed [63:0] I64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;

  function automatic logic signed [63:0] sat64(logic signed [64:0] s);
    if (s[64] != s[63]) return s[64] ? I64_MIN : I64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sext_in(logic [VALUE_W-1:0] v);
    logic [63:0] raw;
    logic [63:0] m;
    raw = {32'd0, v};
    m   = (64'd1 << SB) - 64'd1;
    if (raw[SB-1]) return raw | ~m;
    return raw & m;
  endfunction

  // Configuration.
  logic [MODE_W-1:0] mode_q;
  logic [SPO_W-1:0]  spo_q;
  logic [LEAD_W-1:0] lead_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_AVG;
      spo_q  <= SPO_W'(1);
      lead_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE: mode_q <= cfg_wdata_i[MODE_W-1:0];
        CFG_SPO:  spo_q  <= cfg_wdata_i[SPO_W-1:0];
        CFG_LEAD: lead_q <= cfg_wdata_i[LEAD_W-1:0];
        default:  ;
      endcase
    end
  end

  // Window state.
  logic [CNT_W-1:0]       fill_q, pc_q, j_q;
  logic                   first_win_q;
  logic signed [SB-1:0]   x_q, first_q, latest_q, low_q, high_q, med_a_q, med_b_q;
  logic                   present_q, last_q;
  logic signed [63:0]     sum_q, prod_q, mean_q, oldmean_q, sq_q, calc_q, dif_q;
  logic                   sum_clip_q, prod_clip_q, div_neg_q;

  logic signed [63:0] x64, first64, dmean, dnew;
  logic               in_fire;

  assign x64     = {{(64-SB){x_q[SB-1]}}, x_q};
  assign first64 = {{(64-SB){first_q[SB-1]}}, first_q};
  assign dmean   = x64 - oldmean_q;
  assign dnew    = x64 - mean_q;
  assign in_fire = in_i.valid && cmd_i.in_ready;
  assign in_i.ready = cmd_i.in_ready;

  // Window target for the close test.
  logic [TW-1:0] spo_w, len, lead_w, lead_c, target, fill_next;
  logic          close;

  always_comb begin
    spo_w  = TW'(spo_q);
    lead_w = TW'(lead_q);
    if (spo_w == '0)                    len = TW'(1);
    else if (spo_w > TW'(MAX_WINDOW))   len = TW'(MAX_WINDOW);
    else                                len = spo_w;
    lead_c    = (lead_w > len - TW'(1)) ? (len - TW'(1)) : lead_w;
    target    = first_win_q ? (len - lead_c) : len;
    fill_next = TW'(fill_q) + TW'(1);
    close     = (fill_next >= target) || last_q;
  end

  // Arithmetic units.
  logic               mul_done, mul_clip, div_done, sqrt_done;
  logic signed [63:0] mul_a, mul_b, mul_res;
  logic [63:0]        div_dd, div_q, sqrt_root;
  logic [CNT_W-1:0]   div_dv;
  logic               div_neg;

  always_comb begin
    if (cmd_i.mul_sel == MUL_SQ) begin
      mul_a = dmean;
      mul_b = dnew;
    end else begin
      mul_a = prod_q;
      mul_b = x64;
    end
    case (cmd_i.div_sel)
      DIV_MEAN: begin
        div_dd  = dmean[63] ? (64'd0 - dmean) : dmean;
        div_dv  = pc_q + CNT_W'(1);
        div_neg = dmean[63];
      end
      DIV_AVG: begin
        div_dd  = sum_q[63] ? (64'd0 - sum_q) : sum_q;
        div_dv  = pc_q;
        div_neg = sum_q[63];
      end
      default: begin
        div_dd  = sq_q;
        div_dv  = pc_q;
        div_neg = 1'b0;
      end
    endcase
  end

  dwa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i, .rst_ni,
    .start_i(cmd_i.mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .res_o(mul_res), .clip_o(mul_clip)
  );

  dwa_div #(.DW(CNT_W)) u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_start), .dividend_i(div_dd), .divisor_i(div_dv),
    .done_o(div_done), .quot_o(div_q)
  );

  dwa_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk_i, .rst_ni,
    .start_i(cmd_i.sqrt_start), .q_i(div_q),
    .done_o(sqrt_done), .root_o(sqrt_root)
  );

  logic signed [63:0] div_signed;
  assign div_signed = div_neg_q ? (64'sd0 - div_q) : div_q;

  // Sorted store of the present samples of the window.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [SB-1:0]   ram_wdata, ram_rdata;
  logic            ins_gt;

  assign ins_gt = $signed(ram_rdata) > x_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = x_q;
    ram_raddr = '0;
    if (cmd_i.ins_put0) begin
      ram_we = 1'b1;
    end
    if (cmd_i.ins_go) begin
      ram_raddr = AW'(pc_q - CNT_W'(1));
    end
    if (cmd_i.ins_cmp) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(j_q + CNT_W'(1));
      ram_wdata = ins_gt ? ram_rdata : x_q;
      ram_raddr = AW'(j_q - CNT_W'(1));
    end
    if (cmd_i.med_hi) begin
      ram_raddr = AW'(pc_q >> 1);
    end
    if (cmd_i.med_lo) begin
      ram_raddr = AW'((pc_q >> 1) - CNT_W'(1));
    end
  end

  dwa_ram #(.WIDTH(SB), .DEPTH(MAX_WINDOW)) u_store (
    .clk_i,
    .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  // Control counters and sticky flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      pc_q        <= '0;
      first_win_q <= 1'b1;
      sum_q       <= '0;
      sum_clip_q  <= 1'b0;
      prod_clip_q <= 1'b0;
    end else begin
      if (cmd_i.init || cmd_i.acc) begin
        sum_q <= sat64({sum_q[63], sum_q} + {x64[63], x64});
        if (sat64({sum_q[63], sum_q} + {x64[63], x64}) !=
            (sum_q + x64)) begin
          sum_clip_q <= 1'b1;
        end
      end
      if (cmd_i.prod_load && mul_clip) begin
        prod_clip_q <= 1'b1;
      end
      if (cmd_i.step) begin
        fill_q <= CNT_W'(fill_next);
        if (present_q) pc_q <= pc_q + CNT_W'(1);
      end
      if (cmd_i.emit) begin
        fill_q      <= '0;
        pc_q        <= '0;
        sum_q       <= '0;
        sum_clip_q  <= 1'b0;
        prod_clip_q <= 1'b0;
        first_win_q <= last_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q       <= SB'(sext_in(in_i.sample_value));
      present_q <= in_i.sample_present;
      last_q    <= in_i.last_sample;
    end
    if (cmd_i.init) begin
      first_q  <= x_q;
      low_q    <= x_q;
      high_q   <= x_q;
      latest_q <= x_q;
      prod_q   <= x64;
      mean_q   <= x64;
      sq_q     <= '0;
    end
    if (cmd_i.acc) begin
      if (x_q < low_q)  low_q  <= x_q;
      if (x_q > high_q) high_q <= x_q;
      latest_q  <= x_q;
      oldmean_q <= mean_q;
    end
    if (cmd_i.prod_load) prod_q <= mul_res;
    if (cmd_i.div_start) div_neg_q <= div_neg;
    if (cmd_i.mean_load) mean_q <= oldmean_q + div_signed;
    if (cmd_i.sq_load)   sq_q <= sat64({sq_q[63], sq_q} + {mul_res[63], mul_res});
    if (cmd_i.ins_go)    j_q <= pc_q - CNT_W'(1);
    if (cmd_i.ins_cmp && ins_gt) j_q <= j_q - CNT_W'(1);
    if (cmd_i.close_prep) dif_q <= sat64({sum_q[63], sum_q} - {first64[63], first64});
    if (cmd_i.calc_div)  calc_q <= div_signed;
    if (cmd_i.calc_sqrt) calc_q <= sqrt_root;
    if (cmd_i.med_lo)    med_a_q <= ram_rdata;
    if (cmd_i.med_b)     med_b_q <= ram_rdata;
  end

  // Result selection.
  logic signed [63:0] r_val;
  logic               r_pres, r_sat;
  logic signed [SB:0] range_w, med_sum;

  always_comb begin
    range_w = {high_q[SB-1], high_q} - {low_q[SB-1], low_q};
    med_sum = $signed({med_a_q[SB-1], med_a_q} + {med_b_q[SB-1], med_b_q}) >>> 1;
    r_val   = '0;
    r_pres  = 1'b1;
    r_sat   = 1'b0;
    if (mode_q == MODE_COUNT) begin
      r_val = 64'(pc_q) << FRAC_BITS;
    end else if (pc_q == '0) begin
      r_pres = 1'b0;
    end else begin
      case (mode_q)
        MODE_AVG:    r_val = calc_q;
        MODE_DIFF:   r_val = sat64({first64[63], first64} - {dif_q[63], dif_q});
        MODE_FIRST:  r_val = first64;
        MODE_LAST:   r_val = {{(64-SB){latest_q[SB-1]}}, latest_q};
        MODE_MAX:    r_val = {{(64-SB){high_q[SB-1]}}, high_q};
        MODE_MEDIAN: begin
          if (pc_q[0]) r_val = {{(64-SB){med_a_q[SB-1]}}, med_a_q};
          else         r_val = {{(63-SB){med_sum[SB]}}, med_sum};
        end
        MODE_MIN:    r_val = {{(64-SB){low_q[SB-1]}}, low_q};
        MODE_MUL: begin
          r_val = prod_q;
          r_sat = prod_clip_q;
        end
        MODE_RANGE:  r_val = {{(63-SB){range_w[SB]}}, range_w};
        MODE_STDDEV: r_val = calc_q;
        MODE_SUM: begin
          r_val = sum_q;
          r_sat = sum_clip_q;
        end
        default:     r_pres = 1'b0;
      endcase
    end
  end

  // Output register.
  logic out_valid_q;
  logic out_free;

  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_o.result_value     <= r_val;
      out_o.result_present   <= r_pres;
      out_o.result_saturated <= r_sat;
    end
  end

  assign out_o.valid = out_valid_q;

  always_comb begin
    status_o            = '0;
    status_o.in_valid   = in_i.valid;
    status_o.present    = present_q;
    status_o.pc_zero    = (pc_q == '0);
    status_o.mode       = mode_q;
    status_o.close      = close;
    status_o.ins_gt     = ins_gt;
    status_o.ins_j_zero = (j_q == '0);
    status_o.mul_done   = mul_done;
    status_o.div_done   = div_done;
    status_o.sqrt_done  = sqrt_done;
    status_o.out_free   = out_free;
  end

endmodule

`default_nettype wire

[hw/rtl/downsample_window_aggregator.sv]
// Top level of the downsample window aggregator.
`default_nettype none

// The block groups signed fixed-point samples into windows of
// samples_per_output items, shortening the first window of a stream by
// leading_missing, and emits one aggregate per window chosen by mode. Items
// are taken one at a time. A missing sample only counts towards the window. A
// present sample that opens a window sets the running aggregates and goes to
// the head of the sorted store. Any later present sample goes through the
// product multiply, the running-mean division, the deviation multiply and
// the insertion into the sorted store, which moves up each stored sample
// greater than it. Closing a window adds the close step, then a division
// for the average, a division then a 64-step square root for the standard
// deviation, and reads of the two middle entries for the median. A finished
// result waits in an output register, so the next item is taken while it is
// still pending. The sorted store needs no clearing after reset: only entries
// written in the current window are read.
module downsample_window_aggregator import dwa_pkg::*; #(
  parameter int MAX_WINDOW  = DWA_MAX_WINDOW,
  parameter int SAMPLE_BITS = DWA_SAMPLE_BITS,
  parameter int FRAC_BITS   = DWA_FRAC_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  dwa_in_if.sink                     in_i,
  dwa_out_if.source                  out_o
);

  // Commands from the sequencer and status back from the datapath.
  dwa_cmd_t    cmd;
  dwa_status_t status;

  dwa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .status_i(status),
    .cmd_o(cmd)
  );

  dwa_dp #(
    .MAX_WINDOW(MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_i, .out_o,
    .cmd_i(cmd),
    .status_o(status)
  );

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the downsample window aggregator.
`default_nettype none

module tb;
  import dwa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles allowed for the block to finish items that close no window before
  // the registers change. The worst case is a present sample inserted into a
  // full sorted store.
  localparam int SETTLE_CYCLES = 400;
  // The watchdog ends the run after this many cycles without any item moving
  // on either channel. It covers the long receiver hold-off with margin.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam longint INT64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint INT64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      present;
    logic                      last;
  } sample_item_t;

  typedef struct {
    longint value;
    bit     present;
    bit     saturated;
  } window_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  dwa_in_if in_if ();
  dwa_out_if out_if ();

  downsample_window_aggregator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Items waiting to be offered, and window results waiting to come out.
  sample_item_t   pending_samples[$];
  window_result_t expected_windows[$];

  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          send_hold;
  bit          hold_off_req;
  bit          hold_off_done;
  int unsigned hold_off_left;
  int unsigned quiet_cycles;

  // Shadow of the configuration registers as the predictor sees them.
  logic [MODE_W-1:0] shadow_mode;
  logic [SPO_W-1:0]  shadow_spo;
  logic [LEAD_W-1:0] shadow_lead;

  // Shadow of the window state.
  int unsigned win_fill;
  int unsigned win_present;
  bit          win_first;
  longint      win_sum;
  longint      win_product;
  longint      win_low;
  longint      win_high;
  longint      win_first_val;
  longint      win_latest;
  longint      win_mean;
  longint      win_sq_dev;
  bit          win_sum_clip;
  bit          win_prod_clip;
  longint      win_sorted[DWA_MAX_WINDOW];

  // Clock with an 8 ns period.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Saturating 64-bit addition; clip goes high when the result was limited.
  function automatic longint add_sat(longint a, longint b, inout bit clip);
    if (b > 0 && a > INT64_MAX - b) begin
      clip = 1'b1;
      return INT64_MAX;
    end
    if (b < 0 && a < INT64_MIN - b) begin
      clip = 1'b1;
      return INT64_MIN;
    end
    return a + b;
  endfunction

  function automatic longint sub_sat(longint a, longint b);
    bit unused_clip;
    unused_clip = 1'b0;
    if (b == INT64_MIN) return (a >= 0) ? INT64_MAX : a - INT64_MIN;
    return add_sat(a, -b, unused_clip);
  endfunction

  // Fixed-point product: magnitudes multiplied at full width, the fraction
  // bits dropped, then the sign applied and the result saturated.
  function automatic longint mul_fixed(longint a, longint b, inout bit clip);
    bit          neg;
    bit [127:0]  prod;
    bit [63:0]   ua;
    bit [63:0]   ub;
    bit [63:0]   limit;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 64'd0 - 64'(a) : 64'(a);
    ub = (b < 0) ? 64'd0 - 64'(b) : 64'(b);
    prod = ({64'd0, ua} * {64'd0, ub}) >> DWA_FRAC_BITS;
    limit = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    if (prod[127:64] != 0 || prod[63:0] > limit) begin
      clip = 1'b1;
      return neg ? INT64_MIN : INT64_MAX;
    end
    return neg ? longint'(64'd0 - prod[63:0]) : longint'(prod[63:0]);
  endfunction

  // Integer square root of the variance scaled up by the fraction bits.
  function automatic longint root_scaled(bit [63:0] q);
    bit [127:0] radicand;
    bit [127:0] root;
    bit [127:0] trial;
    radicand = {64'd0, q} << DWA_FRAC_BITS;
    root = 0;
    for (int i = 63; i >= 0; i--) begin
      trial = root | (128'd1 << i);
      if (trial * trial <= radicand) root = trial;
    end
    return longint'(root[63:0]);
  endfunction

  function automatic void clear_window_state();
    win_fill = 0;
    win_present = 0;
    win_sum = 0;
    win_product = 0;
    win_low = 0;
    win_high = 0;
    win_first_val = 0;
    win_latest = 0;
    win_mean = 0;
    win_sq_dev = 0;
    win_sum_clip = 1'b0;
    win_prod_clip = 1'b0;
  endfunction

  // Folds one present sample into every running aggregate at once.
  function automatic void accumulate_sample(longint x);
    longint      old_mean;
    bit          unused_clip;
    int unsigned slot;
    unused_clip = 1'b0;
    if (win_present == 0) begin
      win_first_val = x;
      win_low = x;
      win_high = x;
      win_product = x;
      win_mean = x;
      win_sq_dev = 0;
    end else begin
      old_mean = win_mean;
      if (x < win_low) win_low = x;
      if (x > win_high) win_high = x;
      win_product = mul_fixed(win_product, x, win_prod_clip);
      win_mean = old_mean + (x - old_mean) / longint'(win_present + 1);
      win_sq_dev = add_sat(win_sq_dev,
                           mul_fixed(x - old_mean, x - win_mean, unused_clip),
                           unused_clip);
    end
    win_sum = add_sat(win_sum, x, win_sum_clip);
    win_latest = x;
    if (win_present < DWA_MAX_WINDOW) begin
      slot = win_present;
      while (slot > 0 && win_sorted[slot-1] > x) begin
        win_sorted[slot] = win_sorted[slot-1];
        slot--;
      end
      win_sorted[slot] = x;
      win_present++;
    end
  endfunction

  // Aggregate of the window that is closing, as chosen by the mode register.
  function automatic window_result_t window_aggregate();
    window_result_t r;
    longint         mid_sum;
    int unsigned    n;
    n = win_present;
    r.value = 0;
    r.present = 1'b1;
    r.saturated = 1'b0;
    if (shadow_mode == MODE_COUNT) begin
      r.value = longint'(n) << DWA_FRAC_BITS;
      return r;
    end
    if (n == 0 || shadow_mode > MODE_SUM) begin
      r.present = 1'b0;
      return r;
    end
    case (shadow_mode)
      MODE_AVG: r.value = win_sum / longint'(n);
      MODE_DIFF: r.value = sub_sat(win_first_val, sub_sat(win_sum, win_first_val));
      MODE_FIRST: r.value = win_first_val;
      MODE_LAST: r.value = win_latest;
      MODE_MAX: r.value = win_high;
      MODE_MEDIAN: begin
        if (n % 2 == 1) begin
          r.value = win_sorted[n/2];
        end else begin
          mid_sum = win_sorted[n/2] + win_sorted[n/2-1];
          r.value = (mid_sum - (mid_sum & 64'sd1)) / 2;
        end
      end
      MODE_MIN: r.value = win_low;
      MODE_MUL: begin
        r.value = win_product;
        r.saturated = win_prod_clip;
      end
      MODE_RANGE: r.value = win_high - win_low;
      MODE_STDDEV: r.value = root_scaled(64'(win_sq_dev) / 64'(n));
      default: begin
        r.value = win_sum;
        r.saturated = win_sum_clip;
      end
    endcase
    return r;
  endfunction

  // Advances the shadow state by one accepted item and queues the window
  // result when the item closes a window.
  function automatic void predict_sample(sample_item_t s);
    int unsigned len;
    int unsigned lead;
    int unsigned target;
    len = shadow_spo;
    if (len == 0) len = 1;
    if (len > DWA_MAX_WINDOW) len = DWA_MAX_WINDOW;
    target = len;
    if (win_first) begin
      lead = shadow_lead;
      if (lead > len - 1) lead = len - 1;
      target = len - lead;
    end
    if (s.present) accumulate_sample(longint'(s.value));
    win_fill++;
    if (win_fill >= target || s.last) begin
      expected_windows.push_back(window_aggregate());
      clear_window_state();
      win_first = s.last;
    end
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t: %s got %0d expected %0d", $time, field, got, want);
    error_count++;
  endtask

  // Sender: a new item is put up only when the previous one was taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.sample_value <= '0;
      in_if.sample_present <= 1'b0;
      in_if.last_sample <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (pending_samples.size() > 0 && !send_hold &&
          $urandom_range(99) >= send_idle_pct) begin
        in_if.valid <= 1'b1;
        in_if.sample_value <= pending_samples[0].value;
        in_if.sample_present <= pending_samples[0].present;
        in_if.last_sample <= pending_samples[0].last;
        void'(pending_samples.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted down here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_off_left <= 0;
      hold_off_done <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      out_if.ready <= 1'b0;
    end else if (hold_off_req && !hold_off_done) begin
      hold_off_left <= HOLD_OFF_CYCLES;
      hold_off_done <= 1'b1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts at input acceptance and checks at output acceptance.
  // Values are read at the edge, before the nonblocking updates land.
  always @(posedge clk_i) begin
    sample_item_t   taken;
    window_result_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        taken.value = in_if.sample_value;
        taken.present = in_if.sample_present;
        taken.last = in_if.last_sample;
        predict_sample(taken);
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_windows.size() == 0) begin
          $display("%0t: window result with none expected", $time);
          error_count++;
        end else begin
          want = expected_windows.pop_front();
          if (out_if.result_value !== want.value)
            report_mismatch("result_value", out_if.result_value, want.value);
          if (out_if.result_present !== want.present)
            report_mismatch("result_present", out_if.result_present, want.present);
          if (out_if.result_saturated !== want.saturated)
            report_mismatch("result_saturated", out_if.result_saturated,
                            want.saturated);
        end
      end
    end
  end

  // Watchdog on cycles in which no item moves on either channel.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("downsample_window_aggregator: mismatch");
        $finish;
      end
    end
  end

  // Writes all three registers back to back, one per clock edge. The write
  // enable stays high across them and drops after the last one.
  task automatic write_config(logic [MODE_W-1:0] m, logic [SPO_W-1:0] spo,
                              logic [LEAD_W-1:0] lead);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_MODE;
    cfg_wdata_i <= CFG_DATA_W'(m);
    @(posedge clk_i);
    cfg_idx_i <= CFG_SPO;
    cfg_wdata_i <= CFG_DATA_W'(spo);
    @(posedge clk_i);
    cfg_idx_i <= CFG_LEAD;
    cfg_wdata_i <= CFG_DATA_W'(lead);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_mode = m;
    shadow_spo = spo;
    shadow_lead = lead;
  endtask

  task automatic queue_sample(logic signed [VALUE_W-1:0] v, logic p, logic l);
    sample_item_t s;
    s.value = v;
    s.present = p;
    s.last = l;
    pending_samples.push_back(s);
  endtask

  // Waits until every item was taken and every result arrived, then lets the
  // block finish any item that closes no window.
  task automatic drain();
    while (pending_samples.size() > 0 || in_if.valid || expected_windows.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Random sample value: whole-range noise, values near one so that products
  // stay in range for a while, the extremes, and tiny values.
  function automatic logic signed [VALUE_W-1:0] random_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return VALUE_W'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
      2: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return VALUE_W'($signed($urandom_range(16)) - 8);
    endcase
  endfunction

  function automatic void set_idling(int unsigned phase);
    case (phase % 4)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 53;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 53;
      end
      default: begin
        send_idle_pct = 17;
        recv_stall_pct = 17;
      end
    endcase
  endfunction

  initial begin
    logic [SPO_W-1:0] spo;
    int unsigned      count;
    error_count = 0;
    quiet_cycles = 0;
    send_hold = 1'b0;
    hold_off_req = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_MODE;
    cfg_wdata_i = '0;
    shadow_mode = MODE_AVG;
    shadow_spo = 1;
    shadow_lead = 0;
    win_first = 1'b1;
    clear_window_state();
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The median window of four with two leading missing
    // samples gets a short first window, then the sample extremes, a window
    // with a missing sample, an empty window and a flush by last_sample.
    write_config(MODE_MEDIAN, 4, 2);
    queue_sample(32'sh7fff_ffff, 1'b1, 1'b0);
    queue_sample(32'sh8000_0000, 1'b1, 1'b0);
    queue_sample(32'sh0001_0000, 1'b1, 1'b0);
    queue_sample(-32'sd1, 1'b1, 1'b0);
    queue_sample(32'sd0, 1'b0, 1'b0);
    queue_sample(32'sd3, 1'b1, 1'b0);
    queue_sample(32'sd5, 1'b0, 1'b0);
    queue_sample(32'sd5, 1'b0, 1'b0);
    queue_sample(32'sd5, 1'b0, 1'b0);
    queue_sample(32'sd5, 1'b0, 1'b0);
    queue_sample(32'sd9, 1'b1, 1'b1);
    drain();
    // Count of an empty window is still present; an unknown mode gives an
    // empty result; a zero window length acts as one.
    write_config(MODE_COUNT, 3, 0);
    queue_sample(32'sd7, 1'b0, 1'b0);
    queue_sample(32'sd7, 1'b0, 1'b0);
    queue_sample(32'sd7, 1'b0, 1'b0);
    drain();
    write_config(MODE_W'(13), 0, 0);
    queue_sample(32'sd1, 1'b1, 1'b0);
    queue_sample(32'sd2, 1'b1, 1'b0);
    drain();
    // An overlong window saturates at the maximum, and leading_missing
    // beyond the window length saturates too.
    write_config(MODE_MUL, 9'h1ff, 8'hff);
    queue_sample(32'sh7fff_ffff, 1'b1, 1'b0);
    queue_sample(32'sh7fff_ffff, 1'b1, 1'b0);
    queue_sample(32'sh7fff_ffff, 1'b1, 1'b1);
    queue_sample(32'sh0002_0000, 1'b1, 1'b1);
    drain();

    // Random part: one phase per mode and the unknown modes, each with its
    // own window setting, leading count and idling pattern.
    for (int phase = 0; phase < 14; phase++) begin
      set_idling(phase);
      case ($urandom_range(9))
        0: spo = SPO_W'(256);
        1: spo = SPO_W'($urandom_range(511, 257));
        2: spo = '0;
        default: spo = SPO_W'($urandom_range(8, 1));
      endcase
      if (phase == 3) spo = SPO_W'(1);
      write_config(MODE_W'(phase < 12 ? phase : $urandom_range(15, 12)), spo,
                   LEAD_W'($urandom_range(3) == 0 ? $urandom : $urandom_range(3)));
      count = $urandom_range(34, 24);
      for (int k = 0; k < count; k++)
        queue_sample(random_value(), $urandom_range(3) != 0,
                     k == count - 1 || $urandom_range(49) == 0);
      // Long receiver hold-off while items keep coming in a phase that has
      // windows of one sample: the block fills and stops taking.
      if (phase == 3) hold_off_req = 1'b1;
      drain();
    end

    // The sender pauses here until every result has come, then one last
    // stretch with the sender held back by a flag rather than by drain.
    set_idling(0);
    write_config(MODE_STDDEV, 2, 1);
    send_hold = 1'b1;
    for (int k = 0; k < 12; k++)
      queue_sample(random_value(), 1'b1, k == 11);
    @(posedge clk_i);
    send_hold = 1'b0;
    drain();

    if (error_count == 0) begin
      $display("downsample_window_aggregator: match");
    end else begin
      $display("downsample_window_aggregator: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
